FILE: rtl/spk_pkg.sv
// Shared constants for the Speck block cipher: field widths, register indexes
// and request codes. No dependencies.
`default_nettype none

package spk_pkg;

    localparam int FIELD_BITS   = 24;
    localparam int CFG_IDX_BITS = 2;
    localparam int NUM_KEY_REGS = 4;

    typedef logic [FIELD_BITS-1:0]   field_t;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_KEY_WORD0 = 2'd0;
    localparam cfg_idx_t REG_KEY_WORD1 = 2'd1;
    localparam cfg_idx_t REG_KEY_WORD2 = 2'd2;
    localparam cfg_idx_t REG_KEY_WORD3 = 2'd3;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/spk_req_if.sv
// Request channel of the Speck block cipher: valid/ready and one block item.
// Depends on spk_pkg.
`default_nettype none

interface spk_req_if;
    logic           valid;
    logic           ready;
    logic           req_type;
    spk_pkg::field_t block_x;
    spk_pkg::field_t block_y;

    modport source (output valid, output req_type, output block_x, output block_y,
                    input ready);
    modport sink   (input valid, input req_type, input block_x, input block_y,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/spk_rsp_if.sv
// Result channel of the Speck block cipher: valid/ready and one result block.
// Depends on spk_pkg.
`default_nettype none

interface spk_rsp_if;
    logic            valid;
    logic            ready;
    spk_pkg::field_t out_x;
    spk_pkg::field_t out_y;

    modport source (output valid, output out_x, output out_y, input ready);
    modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

`default_nettype wire

FILE: rtl/spk_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module spk_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 23
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/speck_block_cipher.sv
// Speck block cipher top level: key registers, key schedule sequencer, round
// unit and round-key RAM. Depends on spk_pkg, spk_req_if, spk_rsp_if, spk_ram.
`default_nettype none

// Speck 48/96 with one round unit that reads its round key from a small
// synchronous RAM. An item is taken in the idle state and then runs its
// rounds, one round per cycle; the block takes no new item until the rounds
// are done and it is idle again, and the pace is set by the single round unit
// and the one read port of the round-key RAM. After reset or any key register
// write, the first item first runs the key schedule, which writes one round
// key per cycle and then primes the RAM read in a prepare state before the
// rounds start. A finished result sits in an output register, so the block
// starts the next item while the result waits to be taken.
module speck_block_cipher #(
    parameter int WORD_BITS = 24,
    parameter int KEY_WORDS = 4,
    parameter int ROUNDS    = 23,
    parameter int ROT_RIGHT = 8,
    parameter int ROT_LEFT  = 3
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    spk_req_if.sink                   req,
    spk_rsp_if.source                 rsp,
    input  wire logic                 cfg_we,
    input  wire spk_pkg::cfg_idx_t    cfg_idx,
    input  wire spk_pkg::field_t      cfg_data
);

    import spk_pkg::*;

    localparam int AW = $clog2(ROUNDS);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [AW-1:0]        addr_t;
    typedef enum logic [2:0] {ST_IDLE, ST_SCHED, ST_PREP, ST_RUN, ST_HOLD} state_t;

    localparam addr_t LAST_IDX = AW'(ROUNDS - 1);

    function automatic word_t to_word(field_t v);
        logic [FIELD_BITS+64-1:0] t;
        t = {64'b0, v};
        return t[WORD_BITS-1:0];
    endfunction

    function automatic field_t to_field(word_t w);
        logic [WORD_BITS+FIELD_BITS-1:0] t;
        t = {{FIELD_BITS{1'b0}}, w};
        return t[FIELD_BITS-1:0];
    endfunction

    function automatic word_t ror(word_t w, int r);
        return (w >> r) | (w << (WORD_BITS - r));
    endfunction

    function automatic word_t rol(word_t w, int r);
        return (w << r) | (w >> (WORD_BITS - r));
    endfunction

    function automatic addr_t first_addr(logic op);
        return (op == OP_DECRYPT) ? LAST_IDX : '0;
    endfunction

    state_t state_reg;
    logic   keys_ready_reg;
    field_t key_reg [NUM_KEY_REGS];
    word_t  lw_reg [KEY_WORDS-1];
    word_t  sa_reg;
    addr_t  sched_cnt_reg;
    addr_t  round_cnt_reg;
    addr_t  kaddr_reg;
    logic   op_reg;
    word_t  x_reg, y_reg;
    logic   out_valid_reg;
    field_t out_x_reg, out_y_reg;

    logic   in_accept, slot_free;
    logic   ram_we, ram_re;
    addr_t  ram_rd_addr, kaddr_next;
    word_t  ram_wr_data, round_key;
    word_t  rc, sched_a, sched_b;
    word_t  enc_a, enc_y, dec_b, dec_a, dec_x;
    word_t  new_x, new_y;

    assign in_accept = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.out_x = out_x_reg;
    assign rsp.out_y = out_y_reg;

    // Key schedule round: the round index plays the part of the round key.
    assign rc      = WORD_BITS'(sched_cnt_reg - AW'(1));
    assign sched_b = (ror(lw_reg[0], ROT_RIGHT) + sa_reg) ^ rc;
    assign sched_a = rol(sa_reg, ROT_LEFT) ^ sched_b;

    assign ram_we      = (state_reg == ST_SCHED);
    assign ram_wr_data = (sched_cnt_reg == '0) ? to_word(key_reg[REG_KEY_WORD0]) : sched_a;

    // Round unit, forward and inverse.
    assign enc_a = (ror(x_reg, ROT_RIGHT) + y_reg) ^ round_key;
    assign enc_y = rol(y_reg, ROT_LEFT) ^ enc_a;
    assign dec_b = ror(x_reg ^ y_reg, ROT_LEFT);
    assign dec_a = (x_reg ^ round_key) - dec_b;
    assign dec_x = rol(dec_a, ROT_RIGHT);
    assign new_x = (op_reg == OP_DECRYPT) ? dec_x : enc_a;
    assign new_y = (op_reg == OP_DECRYPT) ? dec_b : enc_y;

    assign kaddr_next = (op_reg == OP_DECRYPT) ? kaddr_reg - AW'(1) : kaddr_reg + AW'(1);

    always_comb
    begin
        ram_re      = 1'b0;
        ram_rd_addr = kaddr_next;
        case (state_reg)
            ST_IDLE:
            begin
                ram_re      = in_accept && keys_ready_reg;
                ram_rd_addr = first_addr(req.req_type);
            end
            ST_PREP:
            begin
                ram_re      = 1'b1;
                ram_rd_addr = first_addr(op_reg);
            end
            ST_RUN:
            begin
                ram_re = (round_cnt_reg != LAST_IDX);
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    spk_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ROUNDS)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (sched_cnt_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_re),
        .rd_addr (ram_rd_addr),
        .rd_data (round_key)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            keys_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            sched_cnt_reg  <= '0;
            round_cnt_reg  <= '0;
            for (int i = 0; i < NUM_KEY_REGS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else
        begin
            if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                keys_ready_reg <= 1'b0;
                case (cfg_idx)
                    REG_KEY_WORD0: key_reg[0] <= cfg_data;
                    REG_KEY_WORD1: key_reg[1] <= cfg_data;
                    REG_KEY_WORD2: key_reg[2] <= cfg_data;
                    REG_KEY_WORD3: key_reg[3] <= cfg_data;
                    default:       key_reg[0] <= key_reg[0];
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        op_reg        <= req.req_type;
                        x_reg         <= to_word(req.block_x);
                        y_reg         <= to_word(req.block_y);
                        round_cnt_reg <= '0;
                        sched_cnt_reg <= '0;
                        kaddr_reg     <= first_addr(req.req_type);
                        state_reg     <= keys_ready_reg ? ST_RUN : ST_SCHED;
                    end
                end
                ST_SCHED:
                begin
                    if (sched_cnt_reg == '0)
                    begin
                        sa_reg <= to_word(key_reg[REG_KEY_WORD0]);
                        for (int j = 0; j < KEY_WORDS - 1; j++)
                        begin
                            lw_reg[j] <= to_word(key_reg[j+1]);
                        end
                    end
                    else
                    begin
                        sa_reg <= sched_a;
                        for (int j = 0; j < KEY_WORDS - 2; j++)
                        begin
                            lw_reg[j] <= lw_reg[j+1];
                        end
                        lw_reg[KEY_WORDS-2] <= sched_b;
                    end
                    if (sched_cnt_reg == LAST_IDX)
                    begin
                        keys_ready_reg <= 1'b1;
                        state_reg      <= ST_PREP;
                    end
                    else
                    begin
                        sched_cnt_reg <= sched_cnt_reg + AW'(1);
                    end
                end
                ST_PREP:
                begin
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    x_reg <= new_x;
                    y_reg <= new_y;
                    if (round_cnt_reg == LAST_IDX)
                    begin
                        if (slot_free)
                        begin
                            out_valid_reg <= 1'b1;
                            out_x_reg     <= to_field(new_x);
                            out_y_reg     <= to_field(new_y);
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_HOLD;
                        end
                    end
                    else
                    begin
                        round_cnt_reg <= round_cnt_reg + AW'(1);
                        kaddr_reg     <= kaddr_next;
                    end
                end
                ST_HOLD:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= to_field(x_reg);
                        out_y_reg     <= to_field(y_reg);
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/spk_checker.sv
// Port-level checks for the Speck block cipher, and the bind that attaches
// them to the top level. Depends on spk_pkg and speck_block_cipher.
`default_nettype none

module spk_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_ready,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire spk_pkg::field_t out_x,
    input wire spk_pkg::field_t out_y
);

    // A stalled result must keep its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y))
        else $error("result changed or dropped while stalled");

    // One item at a time: taking an item closes the input for the next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after an item");

    // An item runs all its rounds before its result is registered, so no result can appear right after an item.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared the cycle after an item was taken");

endmodule

bind speck_block_cipher spk_checker u_spk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_x     (rsp.out_x),
    .out_y     (rsp.out_y)
);

`default_nettype wire
